// ===== rtl/trdc_pkg.sv =====
// Shared types and codes for the tank refuel / drive cycle sequencer.
// No dependencies.
`default_nettype none
package trdc_pkg;

    localparam int unsigned PRESS_W = 24;
    localparam int unsigned TEMP_W  = 16;
    localparam int unsigned DENS_W  = 20;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned CFG_AW  = 3;
    localparam int unsigned CFG_DW  = 24;

    localparam logic [MODE_W-1:0] MODE_REFUEL   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DRIVE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FINISH   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MIN_P    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MAX_T    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MIN_T    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_OVERFLOW = 3'd6;
    localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd7;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    localparam logic [CFG_AW-1:0] CFG_MIN_DENSITY  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_MAX_DENSITY  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_MIN_TEMP     = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_MAX_TEMP     = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_MIN_PRESSURE = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_REFUEL_COUNT = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_STOP_AFTER   = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_INIT_STATE   = 3'd7;

    typedef struct packed {
        logic [DENS_W-1:0]  min_density;
        logic [DENS_W-1:0]  max_density;
        logic [TEMP_W-1:0]  min_temperature;
        logic [TEMP_W-1:0]  max_temperature;
        logic [PRESS_W-1:0] min_pressure;
        logic [CNT_W-1:0]   refuel_count;
        logic               stop_after_refuel;
        logic [MODE_W-1:0]  initial_state;
    } t_cfg;

    typedef struct packed {
        logic               func;
        logic [PRESS_W-1:0] tank_pressure;
        logic [TEMP_W-1:0]  tank_temperature;
        logic [DENS_W-1:0]  tank_density;
        logic [PRESS_W-1:0] ramp_rate;
        logic [PRESS_W-1:0] target_pressure;
    } t_item;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [PRESS_W-1:0] latched_target;
        logic [CNT_W-1:0]   refuels_started;
        logic [PRESS_W-1:0] held_start_pressure;
        logic [PRESS_W-1:0] held_ramp;
        logic               held_valve;
    } t_ctx;

    typedef struct packed {
        logic               not_started;
        logic               switched;
        logic               valve_open;
        logic [PRESS_W-1:0] ramp_out;
        logic [PRESS_W-1:0] start_pressure;
        logic [MODE_W-1:0]  state;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/tank_refuel_drive_cycle_fsm.sv =====
// Top level of the tank refuel / drive cycle sequencer: input register,
// step logic, cycle state and result register. Depends on trdc_pkg,
// trdc_cfg_regs and trdc_step.
//
// Usage:
//   Input items enter on the s_axis channel: tuser carries the command
//   (0 start, 1 step), tdata the tank measurements and targets. Each item
//   gives exactly one result on the m_axis channel, in order.
//   An accepted item is held in the input register; the step logic
//   then updates the cycle state and loads the result register, from
//   which the result is presented on the m_axis channel.
//   Throughput is one item per clock: the input register advances whenever
//   the result register is empty or being drained in the same cycle.
//   When the receiver stalls, the result is held, the input register fills,
//   and o_s_axis_tready drops; no item is lost or reordered.
//   Configuration registers are written through i_cfg_we / i_cfg_addr /
//   i_cfg_wdata, one write per cycle; the user must write them only while no item is in flight (not enforced).
//   Synchronous active-low reset empties both registers, returns the cycle
//   state to not started and loads the register defaults.
`default_nettype none
module tank_refuel_drive_cycle_fsm (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [trdc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [trdc_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  wire logic                        i_s_axis_tvalid,
    output      logic                        o_s_axis_tready,
    // tank_pressure, tank_temperature, tank_density, ramp_rate,
    // target_pressure, zero pad
    input  wire logic [111:0]                i_s_axis_tdata,
    // func
    input  wire logic [0:0]                  i_s_axis_tuser,
    output      logic                        o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    // state, start_pressure, ramp_out, valve_open, switched, not_started,
    // zero pad
    output      logic [55:0]                 o_m_axis_tdata
);

    trdc_pkg::t_cfg    cfg;
    trdc_pkg::t_item   r_item;
    trdc_pkg::t_ctx    r_ctx;
    trdc_pkg::t_ctx    n_ctx;
    trdc_pkg::t_result r_result;
    trdc_pkg::t_result n_result;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              advance;

    trdc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .o_cfg      (cfg)
    );

    trdc_step u_step (
        .i_cfg   (cfg),
        .i_ctx   (r_ctx),
        .i_item  (r_item),
        .o_ctx   (n_ctx),
        .o_result(n_result)
    );

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctx       <= '{mode: trdc_pkg::MODE_IDLE, default: '0};
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_ctx       <= n_ctx;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item.func             <= i_s_axis_tuser[0];
            r_item.tank_pressure    <= i_s_axis_tdata[23:0];
            r_item.tank_temperature <= i_s_axis_tdata[39:24];
            r_item.tank_density     <= i_s_axis_tdata[59:40];
            r_item.ramp_rate        <= i_s_axis_tdata[83:60];
            r_item.target_pressure  <= i_s_axis_tdata[107:84];
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_result};

endmodule
`default_nettype wire

// ===== rtl/trdc_cfg_regs.sv =====
// Configuration register file for the tank cycle sequencer.
// Depends on trdc_pkg.
`default_nettype none
module trdc_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [trdc_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  wire logic [trdc_pkg::CFG_DW-1:0]   i_cfg_wdata,
    output trdc_pkg::t_cfg                     o_cfg
);

    trdc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_density       <= '0;
            r_cfg.max_density       <= '1;
            r_cfg.min_temperature   <= '0;
            r_cfg.max_temperature   <= '1;
            r_cfg.min_pressure      <= '0;
            r_cfg.refuel_count      <= trdc_pkg::CNT_W'(1);
            r_cfg.stop_after_refuel <= 1'b0;
            r_cfg.initial_state     <= trdc_pkg::MODE_REFUEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                trdc_pkg::CFG_MIN_DENSITY:
                    r_cfg.min_density <= i_cfg_wdata[trdc_pkg::DENS_W-1:0];
                trdc_pkg::CFG_MAX_DENSITY:
                    r_cfg.max_density <= i_cfg_wdata[trdc_pkg::DENS_W-1:0];
                trdc_pkg::CFG_MIN_TEMP:
                    r_cfg.min_temperature <= i_cfg_wdata[trdc_pkg::TEMP_W-1:0];
                trdc_pkg::CFG_MAX_TEMP:
                    r_cfg.max_temperature <= i_cfg_wdata[trdc_pkg::TEMP_W-1:0];
                trdc_pkg::CFG_MIN_PRESSURE:
                    r_cfg.min_pressure <= i_cfg_wdata[trdc_pkg::PRESS_W-1:0];
                trdc_pkg::CFG_REFUEL_COUNT:
                    r_cfg.refuel_count <= i_cfg_wdata[trdc_pkg::CNT_W-1:0];
                trdc_pkg::CFG_STOP_AFTER:
                    r_cfg.stop_after_refuel <= i_cfg_wdata[0];
                trdc_pkg::CFG_INIT_STATE:
                    r_cfg.initial_state <= i_cfg_wdata[trdc_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== rtl/trdc_step.sv =====
// Next-state and result logic for one item of the tank cycle sequencer.
// Depends on trdc_pkg.
`default_nettype none
module trdc_step (
    input  wire trdc_pkg::t_cfg    i_cfg,
    input  wire trdc_pkg::t_ctx    i_ctx,
    input  wire trdc_pkg::t_item   i_item,
    output trdc_pkg::t_ctx    o_ctx,
    output trdc_pkg::t_result o_result
);

    always_comb begin
        logic                           last;
        logic                           do_enter;
        logic                           early;
        logic [trdc_pkg::MODE_W-1:0]    enter_mode;
        trdc_pkg::t_ctx                 ctx;

        ctx        = i_ctx;
        last       = (i_ctx.refuels_started == i_cfg.refuel_count);
        do_enter   = 1'b0;
        early      = 1'b0;
        enter_mode = trdc_pkg::MODE_IDLE;

        if (i_item.func == trdc_pkg::FUNC_START) begin
            ctx.latched_target  = '0;
            ctx.refuels_started = '0;
            if (i_cfg.initial_state == trdc_pkg::MODE_IDLE) begin
                ctx.mode                = trdc_pkg::MODE_IDLE;
                ctx.held_start_pressure = '0;
                ctx.held_ramp           = '0;
                ctx.held_valve          = 1'b0;
            end else begin
                do_enter   = 1'b1;
                enter_mode = i_cfg.initial_state;
            end
        end else begin
            unique case (i_ctx.mode)
                trdc_pkg::MODE_IDLE: early = 1'b1;
                trdc_pkg::MODE_REFUEL: begin
                    if (i_item.tank_density > i_cfg.max_density) begin
                        do_enter   = 1'b1;
                        enter_mode = trdc_pkg::MODE_OVERFLOW;
                    end else if (i_item.tank_pressure >= i_ctx.latched_target) begin
                        do_enter   = 1'b1;
                        enter_mode = (last && i_cfg.stop_after_refuel) ?
                                     trdc_pkg::MODE_FINISH : trdc_pkg::MODE_DRIVE;
                    end else if (i_item.tank_temperature > i_cfg.max_temperature) begin
                        do_enter   = 1'b1;
                        enter_mode = trdc_pkg::MODE_MAX_T;
                    end
                end
                trdc_pkg::MODE_DRIVE: begin
                    if (i_item.tank_density < i_cfg.min_density) begin
                        do_enter   = 1'b1;
                        enter_mode = last ? trdc_pkg::MODE_FINISH : trdc_pkg::MODE_REFUEL;
                    end else if (i_item.tank_temperature < i_cfg.min_temperature) begin
                        do_enter   = 1'b1;
                        enter_mode = trdc_pkg::MODE_MIN_T;
                    end else if (i_item.tank_pressure < i_cfg.min_pressure) begin
                        do_enter   = 1'b1;
                        enter_mode = trdc_pkg::MODE_MIN_P;
                    end
                end
                default: ;
            endcase
        end

        if (do_enter) begin
            ctx.mode                = enter_mode;
            ctx.held_start_pressure = '0;
            ctx.held_ramp           = '0;
            ctx.held_valve          = (enter_mode == trdc_pkg::MODE_DRIVE);
            if (enter_mode == trdc_pkg::MODE_REFUEL) begin
                ctx.latched_target      = i_item.target_pressure;
                ctx.held_start_pressure = i_item.tank_pressure;
                ctx.held_ramp           = i_item.ramp_rate;
                if (ctx.refuels_started != '1) begin
                    ctx.refuels_started = ctx.refuels_started + trdc_pkg::CNT_W'(1);
                end
            end
        end

        o_ctx                   = ctx;
        o_result.state          = ctx.mode;
        o_result.start_pressure = ctx.held_start_pressure;
        o_result.ramp_out       = ctx.held_ramp;
        o_result.valve_open     = ctx.held_valve;
        o_result.switched       = do_enter;
        o_result.not_started    = early;
    end

endmodule
`default_nettype wire

// ===== tb/trdc_cycle_checker.sv =====
// Scoreboard for the tank refuel / drive cycle sequencer: watches the register
// port and both streams, predicts each result and compares it field by field.
// Depends on trdc_pkg.
`default_nettype none
module trdc_cycle_checker
    import trdc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [CFG_DW-1:0] i_cfg_wdata,
    input  wire logic              i_s_axis_tvalid,
    input  wire logic              i_s_axis_tready,
    input  wire logic [111:0]      i_s_axis_tdata,
    input  wire logic [0:0]        i_s_axis_tuser,
    input  wire logic              i_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    input  wire logic [55:0]       i_m_axis_tdata,
    output int                     o_mismatches,
    output int                     o_outstanding,
    output int                     o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg    regs;
    t_ctx    cyc;
    t_result cycle_q[$];
    int      mismatches = 0;
    int      results = 0;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        o_results     = 0;
    end

    function automatic void enter_mode(input logic [MODE_W-1:0] mode, input t_item it);
        cyc.mode                = mode;
        cyc.held_start_pressure = '0;
        cyc.held_ramp           = '0;
        cyc.held_valve          = 1'b0;
        if (mode == MODE_REFUEL) begin
            cyc.latched_target = it.target_pressure;
            if (cyc.refuels_started != '1)
                cyc.refuels_started = cyc.refuels_started + CNT_W'(1);
            cyc.held_start_pressure = it.tank_pressure;
            cyc.held_ramp           = it.ramp_rate;
        end else if (mode == MODE_DRIVE) begin
            cyc.held_valve = 1'b1;
        end
    endfunction

    function automatic t_result advance_cycle(input t_item it);
        t_result           r;
        logic [MODE_W-1:0] next;
        logic              moved;
        logic              last;
        r     = '0;
        next  = cyc.mode;
        moved = 1'b0;
        last  = (cyc.refuels_started == regs.refuel_count);
        if (it.func == FUNC_START) begin
            cyc.latched_target  = '0;
            cyc.refuels_started = '0;
            enter_mode(regs.initial_state, it);
            r.switched = (regs.initial_state != MODE_IDLE);
        end else begin
            case (cyc.mode)
                MODE_IDLE: r.not_started = 1'b1;
                MODE_REFUEL: begin
                    moved = 1'b1;
                    if (it.tank_density > regs.max_density)
                        next = MODE_OVERFLOW;
                    else if (it.tank_pressure >= cyc.latched_target)
                        next = (last && regs.stop_after_refuel) ? MODE_FINISH : MODE_DRIVE;
                    else if (it.tank_temperature > regs.max_temperature)
                        next = MODE_MAX_T;
                    else
                        moved = 1'b0;
                end
                MODE_DRIVE: begin
                    moved = 1'b1;
                    if (it.tank_density < regs.min_density)
                        next = last ? MODE_FINISH : MODE_REFUEL;
                    else if (it.tank_temperature < regs.min_temperature)
                        next = MODE_MIN_T;
                    else if (it.tank_pressure < regs.min_pressure)
                        next = MODE_MIN_P;
                    else
                        moved = 1'b0;
                end
                default: ;
            endcase
            if (moved) begin
                enter_mode(next, it);
                r.switched = 1'b1;
            end
        end
        r.state          = cyc.mode;
        r.start_pressure = cyc.held_start_pressure;
        r.ramp_out       = cyc.held_ramp;
        r.valve_open     = cyc.held_valve;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_item   it;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            regs.min_density       = '0;
            regs.max_density       = '1;
            regs.min_temperature   = '0;
            regs.max_temperature   = '1;
            regs.min_pressure      = '0;
            regs.refuel_count      = 16'd1;
            regs.stop_after_refuel = 1'b0;
            regs.initial_state     = MODE_REFUEL;
            cyc                    = '0;
            cyc.mode               = MODE_IDLE;
            cycle_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MIN_DENSITY:  regs.min_density       = i_cfg_wdata[DENS_W-1:0];
                    CFG_MAX_DENSITY:  regs.max_density       = i_cfg_wdata[DENS_W-1:0];
                    CFG_MIN_TEMP:     regs.min_temperature   = i_cfg_wdata[TEMP_W-1:0];
                    CFG_MAX_TEMP:     regs.max_temperature   = i_cfg_wdata[TEMP_W-1:0];
                    CFG_MIN_PRESSURE: regs.min_pressure      = i_cfg_wdata[PRESS_W-1:0];
                    CFG_REFUEL_COUNT: regs.refuel_count      = i_cfg_wdata[CNT_W-1:0];
                    CFG_STOP_AFTER:   regs.stop_after_refuel = i_cfg_wdata[0];
                    CFG_INIT_STATE:   regs.initial_state     = i_cfg_wdata[MODE_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = t_result'(i_m_axis_tdata[53:0]);
                results++;
                if (cycle_q.size() == 0) begin
                    $error("result item with no expected item waiting: %h", i_m_axis_tdata);
                    mismatches++;
                end else begin
                    want = cycle_q.pop_front();
                    check_field("state", 32'(want.state), 32'(got.state));
                    check_field("start_pressure", 32'(want.start_pressure),
                                32'(got.start_pressure));
                    check_field("ramp_out", 32'(want.ramp_out), 32'(got.ramp_out));
                    check_field("valve_open", 32'(want.valve_open), 32'(got.valve_open));
                    check_field("switched", 32'(want.switched), 32'(got.switched));
                    check_field("not_started", 32'(want.not_started),
                                32'(got.not_started));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                it.func             = i_s_axis_tuser[0];
                it.tank_pressure    = i_s_axis_tdata[23:0];
                it.tank_temperature = i_s_axis_tdata[39:24];
                it.tank_density     = i_s_axis_tdata[59:40];
                it.ramp_rate        = i_s_axis_tdata[83:60];
                it.target_pressure  = i_s_axis_tdata[107:84];
                cycle_q.push_back(advance_cycle(it));
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= cycle_q.size();
        o_results     <= results;
    end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Top of the tank refuel / drive cycle sequencer testbench: clock, reset,
// register setups, directed and randomized item streams, and the verdict.
// Depends on trdc_pkg, tank_refuel_drive_cycle_fsm and trdc_cycle_checker.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import trdc_pkg::*;

    localparam int          CYCLE_LIMIT     = 100_000;
    localparam int          PHASES          = 8;
    localparam int          PHASE_ITEMS     = 190;
    localparam int          PING_PONG_STEPS = 2 * 24 + 8;
    localparam int unsigned P_MAX           = 32'h00FF_FFFF;
    localparam int unsigned T_MAX           = 32'h0000_FFFF;
    localparam int unsigned D_MAX           = 32'h000F_FFFF;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              cfg_we   = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [111:0]      s_tdata  = '0;
    logic [0:0]        s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [55:0]       m_tdata;

    int   mismatches;
    int   outstanding;
    int   results;
    int   cycles = 0;
    bit   quiet  = 1'b0;
    t_cfg setup;

    tank_refuel_drive_cycle_fsm dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    trdc_cycle_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding),
        .o_results       (results)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tank_refuel_drive_cycle_fsm regression: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_tready <= i_rst_n && (quiet || $urandom_range(0, 99) >= 31);
    end

    function automatic t_item tank_item(input logic func, input int unsigned press,
                                        input int unsigned temp, input int unsigned dens,
                                        input int unsigned ramp, input int unsigned target);
        t_item it;
        it.func             = func;
        it.tank_pressure    = PRESS_W'(press);
        it.tank_temperature = TEMP_W'(temp);
        it.tank_density     = DENS_W'(dens);
        it.ramp_rate        = PRESS_W'(ramp);
        it.target_pressure  = PRESS_W'(target);
        return it;
    endfunction

    function automatic int unsigned near_thr(input int unsigned thr, input int unsigned top);
        case ($urandom_range(0, 3))
            0:       return (thr == 0) ? 0 : thr - 1;
            1:       return thr;
            2:       return (thr >= top) ? top : thr + 1;
            default: return $urandom_range(0, 1) ? top : 0;
        endcase
    endfunction

    // mostly inside the safe band, otherwise at or around either limit or anywhere in range
    function automatic int unsigned pick_field(input int unsigned lo, input int unsigned hi,
                                               input int unsigned top);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return $urandom_range(lo, hi);
        else if (roll < 70)
            return near_thr(lo, top);
        else if (roll < 85)
            return near_thr(hi, top);
        return $urandom_range(0, top);
    endfunction

    function automatic t_item random_item(input logic func);
        int unsigned roll;
        int unsigned target;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            target = $urandom_range(0, 65535);
        else if (roll < 90)
            target = $urandom_range(0, P_MAX);
        else
            target = $urandom_range(0, 1) ? P_MAX : 0;
        return tank_item(func,
                         pick_field(32'(setup.min_pressure), P_MAX, P_MAX),
                         pick_field(32'(setup.min_temperature), 32'(setup.max_temperature),
                                    T_MAX),
                         pick_field(32'(setup.min_density), 32'(setup.max_density), D_MAX),
                         $urandom_range(0, P_MAX), target);
    endfunction

    task automatic send_item(input t_item it);
        int gap;
        gap = 0;
        if (!quiet)
            while ($urandom_range(0, 99) < 31)
                gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {4'b0, it.target_pressure, it.ramp_rate, it.tank_density,
                     it.tank_temperature, it.tank_pressure};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // hold off the sender until every outstanding result has drained
    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_setup(input t_cfg c);
        write_reg(CFG_MIN_DENSITY, CFG_DW'(c.min_density));
        write_reg(CFG_MAX_DENSITY, CFG_DW'(c.max_density));
        write_reg(CFG_MIN_TEMP, CFG_DW'(c.min_temperature));
        write_reg(CFG_MAX_TEMP, CFG_DW'(c.max_temperature));
        write_reg(CFG_MIN_PRESSURE, CFG_DW'(c.min_pressure));
        write_reg(CFG_REFUEL_COUNT, CFG_DW'(c.refuel_count));
        write_reg(CFG_STOP_AFTER, CFG_DW'(c.stop_after_refuel));
        write_reg(CFG_INIT_STATE, CFG_DW'(c.initial_state));
        setup = c;
    endtask

    initial begin
        t_cfg c;
        int   init_pick;
        setup.min_density       = '0;
        setup.max_density       = '1;
        setup.min_temperature   = '0;
        setup.max_temperature   = '1;
        setup.min_pressure      = '0;
        setup.refuel_count      = 16'd1;
        setup.stop_after_refuel = 1'b0;
        setup.initial_state     = MODE_REFUEL;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: power-up defaults
        send_item(tank_item(FUNC_STEP, P_MAX, T_MAX, D_MAX, P_MAX, P_MAX));
        send_item(tank_item(FUNC_START, 1234, 100, 50, 777, P_MAX));
        send_item(tank_item(FUNC_STEP, P_MAX - 1, T_MAX, D_MAX, 0, 0));
        send_item(tank_item(FUNC_STEP, P_MAX, 0, 0, P_MAX, 0));
        send_item(tank_item(FUNC_STEP, 0, 0, 0, 0, 0));
        drain();

        c = setup;
        c.min_density       = 10;
        c.max_density       = 1000;
        c.min_temperature   = 100;
        c.max_temperature   = 5000;
        c.min_pressure      = 200;
        c.refuel_count      = 2;
        c.stop_after_refuel = 1'b1;
        c.initial_state     = MODE_REFUEL;
        apply_setup(c);
        // overflow, then a step in a terminal state
        send_item(tank_item(FUNC_START, 100, 300, 500, 40, 500));
        send_item(tank_item(FUNC_STEP, 600, 300, 1001, 41, 9));
        send_item(tank_item(FUNC_STEP, 600, 300, 500, 42, 9));
        // pressure reached beats high temperature; second refuel; then high temperature
        send_item(tank_item(FUNC_START, 100, 300, 500, 43, 500));
        send_item(tank_item(FUNC_STEP, 500, 6000, 500, 44, 9));
        send_item(tank_item(FUNC_STEP, 300, 300, 9, 45, 800));
        send_item(tank_item(FUNC_STEP, 799, 5001, 1000, 46, 9));
        // full cycle ending in finish
        send_item(tank_item(FUNC_START, 100, 300, 500, 47, 500));
        send_item(tank_item(FUNC_STEP, 500, 300, 500, 48, 9));
        send_item(tank_item(FUNC_STEP, 300, 300, 9, 49, 700));
        send_item(tank_item(FUNC_STEP, 700, 300, 500, 50, 9));
        send_item(tank_item(FUNC_STEP, 0, 0, 0, 51, 9));
        // low temperature, low pressure faults while driving
        send_item(tank_item(FUNC_START, 100, 300, 500, 52, 0));
        send_item(tank_item(FUNC_STEP, 200, 300, 500, 53, 9));
        send_item(tank_item(FUNC_STEP, 0, 99, 10, 54, 9));
        send_item(tank_item(FUNC_START, 100, 300, 500, 55, 0));
        send_item(tank_item(FUNC_STEP, 200, 100, 10, 56, 9));
        send_item(tank_item(FUNC_STEP, 199, 100, 10, 57, 9));
        drain();

        // start into not started, then straight into driving
        write_reg(CFG_INIT_STATE, CFG_DW'(MODE_IDLE));
        setup.initial_state = MODE_IDLE;
        send_item(tank_item(FUNC_START, 100, 300, 500, 58, 0));
        send_item(tank_item(FUNC_STEP, 100, 300, 500, 59, 0));
        drain();
        write_reg(CFG_INIT_STATE, CFG_DW'(MODE_DRIVE));
        setup.initial_state = MODE_DRIVE;
        send_item(tank_item(FUNC_START, 100, 300, 500, 60, 0));
        send_item(tank_item(FUNC_STEP, 100, 300, 5, 61, 0));
        drain();

        // back-to-back ping-pong between refuel and drive with no end
        quiet = 1'b1;
        c.min_density       = 1000;
        c.max_density       = '1;
        c.min_temperature   = '0;
        c.max_temperature   = '1;
        c.min_pressure      = '0;
        c.refuel_count      = '0;
        c.stop_after_refuel = 1'b0;
        c.initial_state     = MODE_REFUEL;
        apply_setup(c);
        send_item(tank_item(FUNC_START, 5, 5, 0, 5, 0));
        for (int n = 0; n < PING_PONG_STEPS; n++)
            send_item(tank_item(FUNC_STEP, $urandom_range(0, P_MAX), $urandom_range(0, T_MAX),
                                0, $urandom_range(0, P_MAX), 0));
        drain();
        write_reg(CFG_REFUEL_COUNT, CFG_DW'(16'hFFFF));
        write_reg(CFG_STOP_AFTER, CFG_DW'(1));
        setup.refuel_count      = 16'hFFFF;
        setup.stop_after_refuel = 1'b1;
        repeat (4) send_item(tank_item(FUNC_STEP, P_MAX, 0, 0, P_MAX, 0));
        drain();
        quiet = 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                c = '0;
            end else if (p == 1) begin
                c                   = '1;
                c.initial_state     = MODE_DRIVE;
            end else begin
                c.min_density       = DENS_W'($urandom_range(0, D_MAX / 2));
                c.max_density       = DENS_W'($urandom_range(c.min_density, D_MAX));
                c.min_temperature   = TEMP_W'($urandom_range(0, T_MAX / 2));
                c.max_temperature   = TEMP_W'($urandom_range(T_MAX / 2, T_MAX));
                c.min_pressure      = PRESS_W'($urandom_range(0, P_MAX / 2));
                c.refuel_count      = CNT_W'($urandom_range(0, 3));
                c.stop_after_refuel = 1'($urandom_range(0, 1));
                init_pick           = $urandom_range(0, 11);
                c.initial_state     = (init_pick > 7) ? MODE_REFUEL : MODE_W'(init_pick);
            end
            apply_setup(c);
            quiet = (p == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_item((n == 0 ? $urandom_range(0, 99) < 80
                                               : $urandom_range(0, 99) < 8)
                                      ? FUNC_START : FUNC_STEP));
            drain();
        end
        quiet = 1'b0;

        $display("checked %0d result items: directed transitions, refuel/drive ping-pong",
                 results);
        $display("and %0d randomized register setups including all-zero and all-ones",
                 PHASES);
        if (mismatches == 0) begin
            $display("tank_refuel_drive_cycle_fsm regression: pass");
        end else begin
            $display("tank_refuel_drive_cycle_fsm regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
